// ===== hdl/cpt_pkg.sv =====
`timescale 1ns / 1ps

package cpt_pkg;

    // Coordinate and internal word widths.
    localparam int CW     = 32;             // coordinate, signed Q16.16
    localparam int DW     = CW + 1;         // coordinate difference
    localparam int MW     = 2 * DW;         // one product of two differences
    localparam int PW     = MW + 2;         // dot product of two differences
    localparam int VW     = 2 * PW + 1;     // difference of two dot-product products
    localparam int FW     = VW + 2;         // face denominator
    localparam int AW     = FW + DW;        // numerator accumulator
    localparam int QB     = CW + 2;         // quotient bits produced by the divider
    localparam int XW     = AW + QB;        // divider compare width
    localparam int CNW    = $clog2(QB + 1);

    // Job queue between the front and back parts.
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Region codes.
    localparam logic [2:0] RC_VERT_A  = 3'd0;
    localparam logic [2:0] RC_VERT_B  = 3'd1;
    localparam logic [2:0] RC_EDGE_AB = 3'd2;
    localparam logic [2:0] RC_VERT_C  = 3'd3;
    localparam logic [2:0] RC_EDGE_AC = 3'd4;
    localparam logic [2:0] RC_EDGE_BC = 3'd5;
    localparam logic [2:0] RC_FACE    = 3'd6;
    localparam logic [2:0] RC_DEGEN   = 3'd7;

    typedef logic signed [CW-1:0] coord_t;
    typedef coord_t [2:0]         coord3_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef diff_t [2:0]          diff3_t;
    typedef logic signed [PW-1:0] dot_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        coord_t corner_a_x;
        coord_t corner_a_y;
        coord_t corner_a_z;
        coord_t corner_b_x;
        coord_t corner_b_y;
        coord_t corner_b_z;
        coord_t corner_c_x;
        coord_t corner_c_y;
        coord_t corner_c_z;
    } query_t;

    typedef struct packed {
        coord_t     nearest_x;
        coord_t     nearest_y;
        coord_t     nearest_z;
        logic [2:0] region_code;
    } result_t;

    // One classified job as it waits in the queue.
    typedef struct packed {
        coord3_t a;
        coord3_t b;
        coord3_t c;
        diff3_t  ab;
        diff3_t  ac;
        diff3_t  bc;
        dot_t    d1;
        dot_t    d2;
        dot_t    d3;
        dot_t    d4;
        dot_t    d5;
        dot_t    d6;
        logic    is_a;
        logic    is_b;
        logic    is_c;
        logic    pre_ab;
        logic    pre_ac;
    } job_t;

    typedef struct packed {
        logic [QCW-1:0] count;
        logic           empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SORT,
        BK_MAC,
        BK_NEXT,
        BK_NUM,
        BK_DIVLD,
        BK_DIV,
        BK_FIN
    } back_state_t;

    typedef enum logic [2:0] {
        ST_VC_A,
        ST_VC_B,
        ST_VB_A,
        ST_VB_B,
        ST_VA_A,
        ST_VA_B,
        ST_NUM_A,
        ST_NUM_B
    } step_t;

endpackage

// ===== hdl/closest_point_on_triangle_core.sv =====
`timescale 1ns / 1ps
// Closest point on a triangle, signed Q16.16 coordinates.
// A query (point and three corners) is a transfer at a rising edge where start
// is high and busy is low. Each result is shown on result for one cycle with
// done high; the receiver takes it then and cannot hold it off.
// The front pipeline takes up to one query per cycle while busy is low and
// has three stages (offsets, coordinate products, dot products with vertex
// tests). Classified jobs wait in an eight-entry queue; busy rises when the
// queue plus the front pipeline would be full, and is high from reset until the next clock edge.
// The back unit works one job at a time with a single shift-and-add
// multiplier and a restoring divider of 34 steps. A vertex A or B result
// needs no product; other regions need two to six classifying products,
// then per axis one or two numerator products and a divide, a face result
// needing the most work. A query passes the three front stages into the
// queue, waits there and then takes the back time; the back unit sets
// the sustained rate.
// Reset empties the queue and discards any job in progress.

module closest_point_on_triangle_core
    import cpt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  query_t  query,
    output logic    done,
    output result_t result
);

    queue_status_t status;
    logic          push, pop;
    job_t          push_job, pop_job;

    // Front: offsets, dot products and early region tests.
    cpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .query    (query),
        .status   (status),
        .push     (push),
        .push_job (push_job)
    );

    // Job queue between the two parts.
    cpt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (status)
    );

    // Back: remaining region tests and rounded quotients.
    cpt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .status  (status),
        .pop_job (pop_job),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

endmodule

// ===== hdl/cpt_front.sv =====
`timescale 1ns / 1ps

module cpt_front
    import cpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  query_t        query,
    input  queue_status_t status,
    output logic          push,
    output job_t          push_job
);

    logic ready_reg, v1_reg, v2_reg, v3_reg;
    logic accept;

    coord3_t a_in, b_in, c_in, p_in;
    coord3_t a1_reg, b1_reg, c1_reg, a2_reg, b2_reg, c2_reg;
    diff3_t  ab1_next, ac1_next, bc1_next;
    diff3_t  ab1_reg, ac1_reg, bc1_reg, ab2_reg, ac2_reg, bc2_reg;
    diff3_t  pv1_next [3];
    diff3_t  pv1_reg  [3];
    logic signed [MW-1:0] pr2_next [6][3];
    logic signed [MW-1:0] pr2_reg  [6][3];
    dot_t    dsum [6];
    job_t    job_next, job_reg;
    logic [QCW:0] fill;

    // The queue must hold every job that is still in the front pipeline.
    assign fill   = (QCW+1)'(status.count) + (QCW+1)'(v1_reg) + (QCW+1)'(v2_reg)
                  + (QCW+1)'(v3_reg);
    assign busy   = !ready_reg || (fill >= (QCW+1)'(QDEPTH));
    assign accept = start && !busy;

    assign a_in = {query.corner_a_z, query.corner_a_y, query.corner_a_x};
    assign b_in = {query.corner_b_z, query.corner_b_y, query.corner_b_x};
    assign c_in = {query.corner_c_z, query.corner_c_y, query.corner_c_x};
    assign p_in = {query.point_z, query.point_y, query.point_x};

    // Stage 1: edge vectors and point offsets.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ab1_next[k]    = DW'(b_in[k]) - DW'(a_in[k]);
            ac1_next[k]    = DW'(c_in[k]) - DW'(a_in[k]);
            bc1_next[k]    = DW'(c_in[k]) - DW'(b_in[k]);
            pv1_next[0][k] = DW'(p_in[k]) - DW'(a_in[k]);
            pv1_next[1][k] = DW'(p_in[k]) - DW'(b_in[k]);
            pv1_next[2][k] = DW'(p_in[k]) - DW'(c_in[k]);
        end
    end

    // Stage 2: the eighteen coordinate products of the six dot products.
    always_comb
    begin
        for (int p = 0; p < 3; p++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pr2_next[2*p][k]   = MW'(ab1_reg[k]) * MW'(pv1_reg[p][k]);
                pr2_next[2*p+1][k] = MW'(ac1_reg[k]) * MW'(pv1_reg[p][k]);
            end
        end
    end

    // Stage 3: dot-product sums and the tests that need nothing more.
    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            dsum[j] = PW'(pr2_reg[j][0]) + PW'(pr2_reg[j][1]) + PW'(pr2_reg[j][2]);
        end
        job_next.a      = a2_reg;
        job_next.b      = b2_reg;
        job_next.c      = c2_reg;
        job_next.ab     = ab2_reg;
        job_next.ac     = ac2_reg;
        job_next.bc     = bc2_reg;
        job_next.d1     = dsum[0];
        job_next.d2     = dsum[1];
        job_next.d3     = dsum[2];
        job_next.d4     = dsum[3];
        job_next.d5     = dsum[4];
        job_next.d6     = dsum[5];
        job_next.is_a   = (dsum[0][PW-1] || dsum[0] == '0)
                       && (dsum[1][PW-1] || dsum[1] == '0);
        job_next.is_b   = !dsum[2][PW-1] && (dsum[3] <= dsum[2]);
        job_next.is_c   = !dsum[5][PW-1] && (dsum[4] <= dsum[5]);
        job_next.pre_ab = (ab2_reg != '0) && !dsum[0][PW-1]
                       && (dsum[2][PW-1] || dsum[2] == '0);
        job_next.pre_ac = !dsum[1][PW-1] && (dsum[5][PW-1] || dsum[5] == '0);
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            ready_reg <= 1'b1;
            v1_reg    <= accept;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a1_reg  <= a_in;
            b1_reg  <= b_in;
            c1_reg  <= c_in;
            ab1_reg <= ab1_next;
            ac1_reg <= ac1_next;
            bc1_reg <= bc1_next;
            pv1_reg <= pv1_next;
        end
        if (v1_reg)
        begin
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            c2_reg  <= c1_reg;
            ab2_reg <= ab1_reg;
            ac2_reg <= ac1_reg;
            bc2_reg <= bc1_reg;
            pr2_reg <= pr2_next;
        end
        if (v2_reg)
        begin
            job_reg <= job_next;
        end
    end

    assign push     = v3_reg;
    assign push_job = job_reg;

endmodule

// ===== hdl/cpt_queue.sv =====
`timescale 1ns / 1ps

module cpt_queue
    import cpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          pop_job,
    output queue_status_t status
);

    job_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg;

    // Storage is written on a push transfer.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCW'(push) - QCW'(pop);
        end
    end

    assign pop_job      = mem_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);

endmodule

// ===== hdl/cpt_back.sv =====
`timescale 1ns / 1ps

module cpt_back
    import cpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t status,
    input  job_t          pop_job,
    output logic          pop,
    output logic          done,
    output result_t       result
);

    localparam logic signed [CW+3:0] SUM_MAX = signed'({5'b0, {(CW-1){1'b1}}});
    localparam logic signed [CW+3:0] SUM_MIN = signed'({5'b11111, {(CW-1){1'b0}}});
    localparam coord_t OUT_MAX = signed'({1'b0, {(CW-1){1'b1}}});
    localparam coord_t OUT_MIN = signed'({1'b1, {(CW-1){1'b0}}});

    back_state_t state_reg, state_next;
    step_t       step_reg, step_next;
    job_t        item_reg, item_next;
    logic signed [VW-1:0] vc_reg, vc_next, vb_reg, vb_next, coef_reg, coef_next;
    logic signed [AW-1:0] acc_reg, acc_next, mx_reg, mx_next;
    logic [PW-1:0]        my_reg, my_next;
    diff3_t               edge1_reg, edge1_next, edge2_reg, edge2_next;
    coord3_t              base_reg, base_next, res_reg, res_next;
    logic [2:0]           code_reg, code_next;
    logic                 face_reg, face_next;
    logic [FW-1:0]        den_mag_reg, den_mag_next;
    logic                 den_neg_reg, den_neg_next;
    logic [1:0]           axis_reg, axis_next;
    logic [AW-1:0]        rem_reg, rem_next;
    logic [XW-1:0]        dsh_reg, dsh_next;
    logic [QB-1:0]        q_reg, q_next;
    logic                 qneg_reg, qneg_next, ovf_reg, ovf_next;
    logic [CNW-1:0]       cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    result_t              result_reg, result_next;

    // Decision helpers.
    logic                  ld_mac, ld_clear, ld_sub, ld_den, ld_edge, emit_now;
    logic signed [AW-1:0]  ld_x;
    logic signed [PW:0]    ld_y;
    logic signed [FW-1:0]  den_sel, face_den;
    logic signed [PW:0]    e_val, f_val;
    logic signed [VW-1:0]  edge_coef;
    diff3_t                edge_vec;
    coord3_t               edge_base, emit_pt;
    logic [2:0]            edge_code, emit_code;
    logic [AW-1:0]         n_mag;
    logic                  take, rnd, acc_le0;
    logic [QB:0]           q_round;
    logic signed [CW+3:0]  q_signed, sum;
    coord_t                coord_out;

    // Multiplicand with the sign of the multiplier and of the operation folded in.
    function automatic logic signed [AW-1:0] mac_x(input logic signed [AW-1:0] x,
                                                    input logic signed [PW:0] y,
                                                    input logic sub);
        mac_x = (y[PW] ^ sub) ? -x : x;
    endfunction

    function automatic logic [PW-1:0] mac_y(input logic signed [PW:0] y);
        logic signed [PW:0] m;
        m     = y[PW] ? -y : y;
        mac_y = m[PW-1:0];
    endfunction

    // Sequencer: one shift-and-add multiplier and one restoring divider.
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        item_next    = item_reg;
        vc_next      = vc_reg;
        vb_next      = vb_reg;
        coef_next    = coef_reg;
        acc_next     = acc_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;
        edge1_next   = edge1_reg;
        edge2_next   = edge2_reg;
        base_next    = base_reg;
        res_next     = res_reg;
        code_next    = code_reg;
        face_next    = face_reg;
        den_mag_next = den_mag_reg;
        den_neg_next = den_neg_reg;
        axis_next    = axis_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        q_next       = q_reg;
        qneg_next    = qneg_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        pop          = 1'b0;

        ld_mac    = 1'b0;
        ld_clear  = 1'b0;
        ld_sub    = 1'b0;
        ld_den    = 1'b0;
        ld_edge   = 1'b0;
        emit_now  = 1'b0;
        ld_x      = '0;
        ld_y      = '0;
        den_sel   = '0;
        edge_coef = '0;
        edge_vec  = item_reg.ab;
        edge_base = item_reg.a;
        edge_code = RC_EDGE_AB;
        emit_pt   = item_reg.a;
        emit_code = RC_VERT_A;

        e_val    = (PW+1)'(item_reg.d4) - (PW+1)'(item_reg.d3);
        f_val    = (PW+1)'(item_reg.d5) - (PW+1)'(item_reg.d6);
        face_den = FW'(acc_reg) + FW'(vb_reg) + FW'(vc_reg);
        acc_le0  = acc_reg[AW-1] || (acc_reg == '0);
        n_mag    = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
        take     = (XW'(rem_reg) >= dsh_reg);
        rnd      = (den_mag_reg != '0) && !ovf_reg
                && ({rem_reg[FW-1:0], 1'b0} >= (FW+1)'(den_mag_reg));
        q_round  = (QB+1)'(q_reg) + (QB+1)'(rnd);
        q_signed = signed'((CW+4)'(q_round));
        sum      = (CW+4)'(base_reg[axis_reg]) + (qneg_reg ? -q_signed : q_signed);
        if (ovf_reg)
        begin
            coord_out = qneg_reg ? OUT_MIN : OUT_MAX;
        end
        else if (sum > SUM_MAX)
        begin
            coord_out = OUT_MAX;
        end
        else if (sum < SUM_MIN)
        begin
            coord_out = OUT_MIN;
        end
        else
        begin
            coord_out = sum[CW-1:0];
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (!status.empty)
                begin
                    pop        = 1'b1;
                    item_next  = pop_job;
                    state_next = BK_SORT;
                end
            end
            BK_SORT:
            begin
                if (item_reg.is_a)
                begin
                    emit_now = 1'b1;
                end
                else if (item_reg.is_b)
                begin
                    emit_now  = 1'b1;
                    emit_pt   = item_reg.b;
                    emit_code = RC_VERT_B;
                end
                else
                begin
                    ld_mac    = 1'b1;
                    ld_clear  = 1'b1;
                    ld_x      = AW'(item_reg.d1);
                    ld_y      = (PW+1)'(item_reg.d4);
                    step_next = ST_VC_A;
                end
            end
            BK_MAC:
            begin
                if (my_reg == '0)
                begin
                    state_next = BK_NEXT;
                end
                else
                begin
                    if (my_reg[0])
                    begin
                        acc_next = acc_reg + mx_reg;
                    end
                    mx_next = mx_reg <<< 1;
                    my_next = my_reg >> 1;
                end
            end
            BK_NEXT:
            begin
                case (step_reg)
                    ST_VC_A:
                    begin
                        ld_mac    = 1'b1;
                        ld_sub    = 1'b1;
                        ld_x      = AW'(item_reg.d3);
                        ld_y      = (PW+1)'(item_reg.d2);
                        step_next = ST_VC_B;
                    end
                    ST_VC_B:
                    begin
                        vc_next = VW'(acc_reg);
                        if (item_reg.pre_ab && acc_le0)
                        begin
                            ld_edge   = 1'b1;
                            edge_coef = VW'(item_reg.d1);
                            den_sel   = FW'(item_reg.d1) - FW'(item_reg.d3);
                        end
                        else if (item_reg.is_c)
                        begin
                            emit_now  = 1'b1;
                            emit_pt   = item_reg.c;
                            emit_code = RC_VERT_C;
                        end
                        else
                        begin
                            ld_mac    = 1'b1;
                            ld_clear  = 1'b1;
                            ld_x      = AW'(item_reg.d5);
                            ld_y      = (PW+1)'(item_reg.d2);
                            step_next = ST_VB_A;
                        end
                    end
                    ST_VB_A:
                    begin
                        ld_mac    = 1'b1;
                        ld_sub    = 1'b1;
                        ld_x      = AW'(item_reg.d1);
                        ld_y      = (PW+1)'(item_reg.d6);
                        step_next = ST_VB_B;
                    end
                    ST_VB_B:
                    begin
                        vb_next = VW'(acc_reg);
                        if (item_reg.pre_ac && acc_le0)
                        begin
                            ld_edge   = 1'b1;
                            edge_coef = VW'(item_reg.d2);
                            edge_vec  = item_reg.ac;
                            edge_code = RC_EDGE_AC;
                            den_sel   = FW'(item_reg.d2) - FW'(item_reg.d6);
                        end
                        else
                        begin
                            ld_mac    = 1'b1;
                            ld_clear  = 1'b1;
                            ld_x      = AW'(item_reg.d3);
                            ld_y      = (PW+1)'(item_reg.d6);
                            step_next = ST_VA_A;
                        end
                    end
                    ST_VA_A:
                    begin
                        ld_mac    = 1'b1;
                        ld_sub    = 1'b1;
                        ld_x      = AW'(item_reg.d5);
                        ld_y      = (PW+1)'(item_reg.d4);
                        step_next = ST_VA_B;
                    end
                    ST_VA_B:
                    begin
                        if (acc_le0 && !e_val[PW] && !f_val[PW])
                        begin
                            ld_edge   = 1'b1;
                            edge_coef = VW'(e_val);
                            edge_vec  = item_reg.bc;
                            edge_base = item_reg.b;
                            edge_code = RC_EDGE_BC;
                            den_sel   = FW'(e_val) + FW'(f_val);
                        end
                        else if (face_den == '0)
                        begin
                            emit_now  = 1'b1;
                            emit_code = RC_DEGEN;
                        end
                        else
                        begin
                            ld_edge    = 1'b1;
                            edge_coef  = vb_reg;
                            edge_code  = RC_FACE;
                            den_sel    = face_den;
                        end
                    end
                    ST_NUM_A:
                    begin
                        if (face_reg)
                        begin
                            ld_mac    = 1'b1;
                            ld_x      = AW'(vc_reg);
                            ld_y      = (PW+1)'(edge2_reg[axis_reg]);
                            step_next = ST_NUM_B;
                        end
                        else
                        begin
                            state_next = BK_DIVLD;
                        end
                    end
                    ST_NUM_B:
                    begin
                        state_next = BK_DIVLD;
                    end
                    default:
                    begin
                        state_next = BK_IDLE;
                    end
                endcase
            end
            BK_NUM:
            begin
                ld_mac    = 1'b1;
                ld_clear  = 1'b1;
                ld_x      = AW'(coef_reg);
                ld_y      = (PW+1)'(edge1_reg[axis_reg]);
                step_next = ST_NUM_A;
            end
            BK_DIVLD:
            begin
                rem_next  = n_mag;
                qneg_next = acc_reg[AW-1] ^ den_neg_reg;
                q_next    = '0;
                cnt_next  = CNW'(QB);
                dsh_next  = XW'(den_mag_reg) << (QB - 1);
                ovf_next  = (den_mag_reg != '0)
                         && (XW'(n_mag) >= (XW'(den_mag_reg) << QB));
                if ((den_mag_reg == '0) || ovf_next)
                begin
                    state_next = BK_FIN;
                end
                else
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (take)
                begin
                    rem_next = rem_reg - AW'(dsh_reg);
                end
                q_next   = {q_reg[QB-2:0], take};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNW'(1))
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                res_next[axis_reg] = coord_out;
                if (axis_reg == 2'd2)
                begin
                    emit_now           = 1'b1;
                    emit_pt            = res_reg;
                    emit_pt[axis_reg]  = coord_out;
                    emit_code          = code_reg;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = BK_NUM;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // Start an edge or face quotient over the three axes.
        if (ld_edge)
        begin
            ld_den     = 1'b1;
            coef_next  = edge_coef;
            edge1_next = edge_vec;
            edge2_next = item_reg.ac;
            base_next  = edge_base;
            code_next  = edge_code;
            face_next  = (edge_code == RC_FACE);
            axis_next  = 2'd0;
            state_next = BK_NUM;
        end

        if (ld_den)
        begin
            den_neg_next = den_sel[FW-1];
            den_mag_next = den_sel[FW-1] ? FW'(-den_sel) : FW'(den_sel);
        end

        // Load the multiplier for the next product.
        if (ld_mac)
        begin
            mx_next    = mac_x(ld_x, ld_y, ld_sub);
            my_next    = mac_y(ld_y);
            state_next = BK_MAC;
            if (ld_clear)
            begin
                acc_next = '0;
            end
        end

        // Present one result for a single cycle.
        if (emit_now)
        begin
            done_next               = 1'b1;
            result_next.nearest_x   = emit_pt[0];
            result_next.nearest_y   = emit_pt[1];
            result_next.nearest_z   = emit_pt[2];
            result_next.region_code = emit_code;
            state_next              = BK_IDLE;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        item_reg    <= item_next;
        vc_reg      <= vc_next;
        vb_reg      <= vb_next;
        coef_reg    <= coef_next;
        acc_reg     <= acc_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        edge1_reg   <= edge1_next;
        edge2_reg   <= edge2_next;
        base_reg    <= base_next;
        res_reg     <= res_next;
        code_reg    <= code_next;
        face_reg    <= face_next;
        den_mag_reg <= den_mag_next;
        den_neg_reg <= den_neg_next;
        axis_reg    <= axis_next;
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        q_reg       <= q_next;
        qneg_reg    <= qneg_next;
        ovf_reg     <= ovf_next;
        cnt_reg     <= cnt_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/cpt_checker.sv =====
`timescale 1ns / 1ps

module cpt_checker
    import cpt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    localparam int OUT_LIMIT = QDEPTH + 4;

    logic [4:0] outst_reg, outst_next;

    // Queries taken and not yet answered.
    assign outst_next = outst_reg + 5'(start && !busy) - 5'(done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    // Every result answers an earlier query.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (outst_reg != '0))
        else $error("result with no query outstanding");

    // Flow control keeps the queries in flight bounded.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outst_reg <= 5'(OUT_LIMIT))
        else $error("too many queries in flight");

    // The back unit passes through idle and sort for each job, so results never come on consecutive cycles.
    a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on consecutive cycles");

endmodule

bind closest_point_on_triangle_core cpt_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
